FILE: src/debounced_rotary_navigator_core_assert.svh
// assertion macros used by the checker file
`ifndef DEBOUNCED_ROTARY_NAVIGATOR_CORE_ASSERT_SVH
`define DEBOUNCED_ROTARY_NAVIGATOR_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define DRN_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("drn check failed");

// next-cycle implication, off during reset
`define DRN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("drn check failed");

// next-cycle implication that also holds through reset
`define DRN_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("drn check failed");

`endif

FILE: src/drn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drn_pkg
// Types and constants of the debounced rotary navigator.
// ----------------------------------------------------------------------------
package drn_pkg;

   // item kinds
   typedef enum logic {
      REQ_TICK = 1'b0,
      REQ_SET  = 1'b1
   } req_kind_type;

   // register indexes of the write port
   typedef enum logic [1:0] {
      CSR_Y_LOWER_LIMIT       = 2'd0,
      CSR_Y_UPPER_LIMIT       = 2'd1,
      CSR_ROTARY_SETTLE_TICKS = 2'd2,
      CSR_SWITCH_SETTLE_TICKS = 2'd3
   } csr_index_type;

   // reset values and fixed constants
   localparam logic [15:0] ROT_SETTLE_RESET = 16'd2000;
   localparam logic [15:0] SW_SETTLE_RESET  = 16'd20000;
   localparam logic [15:0] START_X          = 16'(320 / 2);
   localparam int          PEND_ROT         = 1;
   localparam int          PEND_SW          = 0;
   // previous pins: A and B high, switch released
   localparam logic [2:0]  PINS_RESET       = 3'b011;

   // one accepted input beat
   typedef struct packed {
      req_kind_type       req_type;
      logic               pin_a;
      logic               pin_b;
      logic               switch_pressed;
      logic [15:0]        new_x;
      logic signed [15:0] new_y;
      logic               notify;
   } item_type;

   // one result beat
   typedef struct packed {
      logic               moved;
      logic               button_event;
      logic               button_down;
      logic [15:0]        pos_x;
      logic signed [15:0] pos_y;
   } result_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic signed [15:0] y_lower_limit;
      logic signed [15:0] y_upper_limit;
      logic [15:0]        rotary_settle_ticks;
      logic [15:0]        switch_settle_ticks;
   } cfg_type;

   // a zero delay acts as one tick
   function automatic logic [15:0] settle_load(input logic [15:0] v);
      settle_load = (v == 16'd0) ? 16'd1 : v;
   endfunction

endpackage

FILE: src/drn_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drn_csr
// Configuration registers: limits and settle delays.
// ----------------------------------------------------------------------------
module drn_csr
   import drn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_Y_LOWER_LIMIT:       cfg_in.y_lower_limit       = $signed(csr_wdata);
            CSR_Y_UPPER_LIMIT:       cfg_in.y_upper_limit       = $signed(csr_wdata);
            CSR_ROTARY_SETTLE_TICKS: cfg_in.rotary_settle_ticks = csr_wdata;
            CSR_SWITCH_SETTLE_TICKS: cfg_in.switch_settle_ticks = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.y_lower_limit       <= 16'sd0;
         cfg_ff.y_upper_limit       <= 16'sd0;
         cfg_ff.rotary_settle_ticks <= ROT_SETTLE_RESET;
         cfg_ff.switch_settle_ticks <= SW_SETTLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: src/drn_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drn_in_reg
// Input register: holds one accepted beat until the datapath takes it.
// ----------------------------------------------------------------------------
module drn_in_reg
   import drn_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  item_type req_item,
   input  logic     advance,
   output logic     item_vld,
   output item_type item
);

   logic     vld_ff;
   logic     vld_in;
   item_type item_ff;
   logic     accept;

   // stall only while a held beat cannot move on
   assign req_stall = vld_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign item_vld  = vld_ff;
   assign item      = item_ff;

   // occupancy
   always_comb begin
      priority if (accept)  vld_in = 1'b1;
      else if (advance)     vld_in = 1'b0;
      else                  vld_in = vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule

FILE: src/drn_nav.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drn_nav
// Debounce state, shared settle counter and clamped quadrature stepping.
// ----------------------------------------------------------------------------
module drn_nav
   import drn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  cfg_type    cfg,
   output logic       has_result,
   output result_type result
);

   logic [2:0]         prev_pins_ff, prev_pins_in;
   logic [1:0]         latched_ab_ff, latched_ab_in;
   logic [1:0]         changed_ab_ff, changed_ab_in;
   logic               latched_press_ff, latched_press_in;
   logic [1:0]         pending_ff, pending_in;
   logic [15:0]        count_ff, count_in;
   logic signed [15:0] y_ff, y_in;
   logic [15:0]        x_ff, x_in;

   logic [1:0]         cur_ab;
   logic [2:0]         cur_pins;
   logic [2:0]         diff;
   logic               rot_edge;
   logic               sw_edge;
   logic [15:0]        count_dec;
   logic               expire;
   logic               ab_eq;
   logic signed [2:0]  step_a;
   logic signed [2:0]  step_b;
   logic signed [17:0] y_sum;
   logic signed [17:0] lo_ext;
   logic signed [17:0] hi_ext;
   logic signed [15:0] y_clamped;
   logic               mv;
   logic               be;
   logic               bd;

   // edge detection against the previous sample
   assign cur_ab    = {item.pin_b, item.pin_a};
   assign cur_pins  = {item.switch_pressed, cur_ab};
   assign diff      = cur_pins ^ prev_pins_ff;
   assign rot_edge  = !pending_ff[PEND_ROT] && (diff[1:0] != 2'b00);
   assign sw_edge   = !pending_ff[PEND_SW] && diff[2];
   assign count_dec = count_ff - 16'd1;
   assign expire    = !rot_edge && !sw_edge && (count_ff == 16'd1);

   // quadrature step: A change counts up when A equals B, B change the opposite
   assign ab_eq  = (cur_ab[0] == cur_ab[1]);
   assign step_a = changed_ab_ff[0] ? (ab_eq ? 3'sd1 : -3'sd1) : 3'sd0;
   assign step_b = changed_ab_ff[1] ? (ab_eq ? -3'sd1 : 3'sd1) : 3'sd0;
   assign y_sum  = 18'(y_ff) + 18'(step_a) + 18'(step_b);
   assign lo_ext = 18'(cfg.y_lower_limit);
   assign hi_ext = 18'(cfg.y_upper_limit);

   // clamp, lower limit first
   always_comb begin
      priority if (y_sum < lo_ext) y_clamped = cfg.y_lower_limit;
      else if (y_sum > hi_ext)     y_clamped = cfg.y_upper_limit;
      else                         y_clamped = y_sum[15:0];
   end

   // next state and result
   always_comb begin
      prev_pins_in     = prev_pins_ff;
      latched_ab_in    = latched_ab_ff;
      changed_ab_in    = changed_ab_ff;
      latched_press_in = latched_press_ff;
      pending_in       = pending_ff;
      count_in         = count_ff;
      y_in             = y_ff;
      x_in             = x_ff;
      mv               = 1'b0;
      be               = 1'b0;
      bd               = 1'b0;
      unique case (item.req_type)
         REQ_SET: begin
            x_in = item.new_x;
            y_in = item.new_y;
            mv   = item.notify;
         end
         REQ_TICK: begin
            prev_pins_in = cur_pins;
            if (rot_edge) begin
               latched_ab_in        = cur_ab;
               changed_ab_in        = diff[1:0];
               pending_in[PEND_ROT] = 1'b1;
               count_in             = settle_load(cfg.rotary_settle_ticks);
            end
            // switch delay loads last and wins
            if (sw_edge) begin
               latched_press_in    = item.switch_pressed;
               pending_in[PEND_SW] = 1'b1;
               count_in            = settle_load(cfg.switch_settle_ticks);
            end
            if (!rot_edge && !sw_edge && (count_ff != 16'd0)) begin
               count_in = count_dec;
            end
            if (expire) begin
               pending_in = 2'b00;
               if (pending_ff[PEND_ROT] && (latched_ab_ff == cur_ab)) begin
                  y_in = y_clamped;
                  mv   = 1'b1;
               end
               if (pending_ff[PEND_SW] && (latched_press_ff == item.switch_pressed)) begin
                  be = 1'b1;
                  bd = latched_press_ff;
               end
            end
         end
      endcase
   end

   assign has_result          = mv || be;
   assign result.moved        = mv;
   assign result.button_event = be;
   assign result.button_down  = bd;
   assign result.pos_x        = x_in;
   assign result.pos_y        = y_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pins_ff     <= PINS_RESET;
         latched_ab_ff    <= 2'b00;
         changed_ab_ff    <= 2'b00;
         latched_press_ff <= 1'b0;
         pending_ff       <= 2'b00;
         count_ff         <= 16'd0;
         y_ff             <= 16'sd0;
         x_ff             <= START_X;
      end else if (advance) begin
         prev_pins_ff     <= prev_pins_in;
         latched_ab_ff    <= latched_ab_in;
         changed_ab_ff    <= changed_ab_in;
         latched_press_ff <= latched_press_in;
         pending_ff       <= pending_in;
         count_ff         <= count_in;
         y_ff             <= y_in;
         x_ff             <= x_in;
      end
   end

endmodule

FILE: src/drn_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drn_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module drn_out_reg
   import drn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic       load_vld,
   input  result_type load_data,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic       free,
   output result_type rsp_data
);

   logic       vld_ff;
   logic       vld_in;
   result_type data_ff;

   // free when empty or being taken this cycle
   assign free      = !vld_ff || !rsp_stall;
   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      priority if (load)  vld_in = load_vld;
      else if (free)      vld_in = 1'b0;
      else                vld_in = vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_vld) begin
         data_ff <= load_data;
      end
   end

endmodule

FILE: src/debounced_rotary_navigator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_rotary_navigator_core
// Debounced quadrature encoder and push switch driving a clamped position.
// ----------------------------------------------------------------------------
// One beat is accepted per clock while req_stall is low. Each beat waits in
// the input register; as it moves on, the step logic writes its result, if
// any, into the result register, which offers it on the result port. The
// next-state logic handles a tick or a set request each clock that a held
// beat moves on. A stalled result holds in the result register while the
// input register still takes a new beat; the input stalls only once both
// hold a beat. Tick beats carry pin samples and advance the shared settle
// counter; set beats store x and y directly. The user must write limits and
// settle delays through the csr port while idle, which is not enforced.
module debounced_rotary_navigator_core
   import drn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic               req_pin_a,
   input  logic               req_pin_b,
   input  logic               req_switch_pressed,
   input  logic [15:0]        req_new_x,
   input  logic signed [15:0] req_new_y,
   input  logic               req_notify,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_moved,
   output logic               rsp_button_event,
   output logic               rsp_button_down,
   output logic [15:0]        rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   item_type   req_item;
   item_type   item;
   logic       item_vld;
   logic       advance;
   logic       out_free;
   logic       has_result;
   result_type result;
   result_type rsp_data;
   cfg_type    cfg;

   // gather the input beat
   assign req_item.req_type       = req_kind_type'(req_type);
   assign req_item.pin_a          = req_pin_a;
   assign req_item.pin_b          = req_pin_b;
   assign req_item.switch_pressed = req_switch_pressed;
   assign req_item.new_x          = req_new_x;
   assign req_item.new_y          = req_new_y;
   assign req_item.notify         = req_notify;

   // a held beat moves on when the result register can take its result
   assign advance = item_vld && out_free;

   drn_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   drn_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .advance   (advance),
      .item_vld  (item_vld),
      .item      (item)
   );

   drn_nav u_nav (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (item),
      .cfg        (cfg),
      .has_result (has_result),
      .result     (result)
   );

   drn_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_vld  (has_result),
      .load_data (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .free      (out_free),
      .rsp_data  (rsp_data)
   );

   // result beat fields
   assign rsp_moved        = rsp_data.moved;
   assign rsp_button_event = rsp_data.button_event;
   assign rsp_button_down  = rsp_data.button_down;
   assign rsp_pos_x        = rsp_data.pos_x;
   assign rsp_pos_y        = rsp_data.pos_y;

endmodule

FILE: src/drn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drn_checker
// Port-level checks of the navigator, bound to the top level.
// ----------------------------------------------------------------------------
`include "debounced_rotary_navigator_core_assert.svh"

module drn_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_moved,
   input logic rsp_button_event,
   input logic rsp_button_down
);

   // a stalled result beat stays offered
   `DRN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // every result reports a move or a switch change
   `DRN_ASSERT_IMPLY(a_rsp_kind, clock, reset, rsp_valid, rsp_moved || rsp_button_event)

   // press flag only comes with a switch event
   `DRN_ASSERT_IMPLY(a_down_event, clock, reset, rsp_valid && rsp_button_down, rsp_button_event)

   // reset empties the result register
   `DRN_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind debounced_rotary_navigator_core drn_checker u_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the debounced rotary navigator core. Encoder and
// switch gestures are sent as tick beats, mixed with position set beats and
// pin noise. An in-bench model of the debounce, quadrature and clamp logic
// predicts each result beat, and the results are compared field by field in
// order. Limits and settle delays change between runs, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import drn_pkg::*;

   localparam int CLOCK_HALF  = 5;
   localparam int RESET_CYCLES = 12;
   localparam int IDLE_GAP    = 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_DIRECTED = 24;
   localparam int CFG_ROW     = 4;
   localparam int SEG_BEATS   = 30;
   localparam int NUM_SEGS    = 4;
   localparam int LONG_SETTLE = 16;

   // how a directed row is checked
   typedef enum logic [1:0] {
      CHK_PRED = 2'd0,
      CHK_NONE = 2'd1,
      CHK_MOVE = 2'd2
   } row_check_type;

   typedef struct packed {
      row_check_type check;
      req_kind_type  kind;
      logic          a;
      logic          b;
      logic          sw;
      logic [15:0]   x;
      logic [15:0]   y;
      logic          notify;
   } dir_row_type;

   // dut signals
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_type = 1'b0;
   logic               req_pin_a = 1'b1;
   logic               req_pin_b = 1'b1;
   logic               req_switch_pressed = 1'b0;
   logic [15:0]        req_new_x = '0;
   logic signed [15:0] req_new_y = '0;
   logic               req_notify = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_moved;
   logic               rsp_button_event;
   logic               rsp_button_down;
   logic [15:0]        rsp_pos_x;
   logic signed [15:0] rsp_pos_y;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   // navigator model state
   cfg_type            nav_cfg;
   logic [2:0]         nav_prev_pins;
   logic [1:0]         nav_latched_ab;
   logic [1:0]         nav_changed_ab;
   logic               nav_latched_press;
   logic [1:0]         nav_pending;
   logic [15:0]        nav_count;
   logic [15:0]        nav_x;
   logic signed [15:0] nav_y;

   // results still owed by the dut
   result_type         pending_results[$];

   // pin levels last sent, {b, a} and switch
   logic [1:0]         pins_now = 2'b11;
   logic               sw_now = 1'b0;

   int                 send_idle_pct = 0;
   int                 stall_pct = 0;
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   int                 beat_count = 0;

   dir_row_type directed_rows [NUM_DIRECTED] = '{
      // reset settings: set beats, quiet ticks
      '{CHK_MOVE, REQ_SET,  1'b0, 1'b0, 1'b0, 16'hFFFF, 16'h8000, 1'b1},
      '{CHK_NONE, REQ_SET,  1'b1, 1'b1, 1'b1, 16'h0000, 16'h7FFF, 1'b0},
      '{CHK_NONE, REQ_TICK, 1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{CHK_NONE, REQ_TICK, 1'b1, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1},
      // limits -1..1, rotary 2, switch 3
      '{CHK_MOVE, REQ_SET,  1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b1},
      // a edge, settles
      '{CHK_PRED, REQ_TICK, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
      // b edge, step into the lower clamp
      '{CHK_PRED, REQ_TICK, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
      // both pins flip, switch press restarts the shared count
      '{CHK_PRED, REQ_TICK, 1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b0},
      // encoder and switch edge together, then a bounce back on a
      '{CHK_PRED, REQ_TICK, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
      // y stored below the lower limit, then a step clamps it
      '{CHK_PRED, REQ_SET,  1'b0, 1'b0, 1'b0, 16'h1234, 16'hFFFB, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{CHK_PRED, REQ_TICK, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0}
   };

   debounced_rotary_navigator_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_pin_a          (req_pin_a),
      .req_pin_b          (req_pin_b),
      .req_switch_pressed (req_switch_pressed),
      .req_new_x          (req_new_x),
      .req_new_y          (req_new_y),
      .req_notify         (req_notify),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_moved          (rsp_moved),
      .rsp_button_event   (rsp_button_event),
      .rsp_button_down    (rsp_button_down),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 100 MHz clock
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // navigator state after reset
   task automatic reset_navigator();
      nav_cfg.y_lower_limit       = '0;
      nav_cfg.y_upper_limit       = '0;
      nav_cfg.rotary_settle_ticks = ROT_SETTLE_RESET;
      nav_cfg.switch_settle_ticks = SW_SETTLE_RESET;
      nav_prev_pins     = PINS_RESET;
      nav_latched_ab    = '0;
      nav_changed_ab    = '0;
      nav_latched_press = 1'b0;
      nav_pending       = '0;
      nav_count         = '0;
      nav_x             = START_X;
      nav_y             = '0;
   endtask

   // debounce, quadrature step and clamp for one beat; returns 1 on a result
   function automatic bit step_navigator(input item_type beat, output result_type res);
      logic [1:0] ab;
      logic [2:0] pins;
      logic [2:0] diff;
      bit         reloaded;
      bit         mv;
      bit         be;
      bit         bd;
      int         y;
      reloaded = 1'b0;
      mv = 1'b0;
      be = 1'b0;
      bd = 1'b0;
      res = '0;
      // set beat stores the position unclamped, no time passes
      if (beat.req_type == REQ_SET) begin
         nav_x = beat.new_x;
         nav_y = beat.new_y;
         res.moved = 1'b1;
         res.pos_x = nav_x;
         res.pos_y = nav_y;
         return beat.notify;
      end
      ab   = {beat.pin_b, beat.pin_a};
      pins = {beat.switch_pressed, ab};
      diff = pins ^ nav_prev_pins;
      // encoder edge latches unless already pending
      if (!nav_pending[PEND_ROT] && diff[1:0] != 2'b00) begin
         nav_latched_ab = ab;
         nav_changed_ab = diff[1:0];
         nav_pending[PEND_ROT] = 1'b1;
         nav_count = (nav_cfg.rotary_settle_ticks == 16'd0) ? 16'd1
                                                          : nav_cfg.rotary_settle_ticks;
         reloaded = 1'b1;
      end
      // switch edge, its delay loads last
      if (!nav_pending[PEND_SW] && diff[2]) begin
         nav_latched_press = beat.switch_pressed;
         nav_pending[PEND_SW] = 1'b1;
         nav_count = (nav_cfg.switch_settle_ticks == 16'd0) ? 16'd1
                                                          : nav_cfg.switch_settle_ticks;
         reloaded = 1'b1;
      end
      nav_prev_pins = pins;
      // shared count down and confirmation on expiry
      if (!reloaded && nav_count != 16'd0) begin
         nav_count = nav_count - 16'd1;
         if (nav_count == 16'd0) begin
            if (nav_pending[PEND_ROT]) begin
               nav_pending[PEND_ROT] = 1'b0;
               if (nav_latched_ab == ab) begin
                  y = nav_y;
                  if (nav_changed_ab[0])
                     y += ab[0] ? (ab[1] ? 1 : -1) : (ab[1] ? -1 : 1);
                  if (nav_changed_ab[1])
                     y += ab[1] ? (ab[0] ? -1 : 1) : (ab[0] ? 1 : -1);
                  if (y < $signed(nav_cfg.y_lower_limit))
                     y = $signed(nav_cfg.y_lower_limit);
                  else if (y > $signed(nav_cfg.y_upper_limit))
                     y = $signed(nav_cfg.y_upper_limit);
                  nav_y = y[15:0];
                  mv = 1'b1;
               end
            end
            if (nav_pending[PEND_SW]) begin
               nav_pending[PEND_SW] = 1'b0;
               if (nav_latched_press == beat.switch_pressed) begin
                  be = 1'b1;
                  bd = nav_latched_press;
               end
            end
         end
      end
      res.moved        = mv;
      res.button_event = be;
      res.button_down  = be && bd;
      res.pos_x        = nav_x;
      res.pos_y        = nav_y;
      return mv || be;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
               what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // drive one input beat from a falling edge until it is taken
   task automatic send_item(input item_type beat, input row_check_type check);
      result_type res;
      bit         has_res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= beat.req_type;
      req_pin_a          <= beat.pin_a;
      req_pin_b          <= beat.pin_b;
      req_switch_pressed <= beat.switch_pressed;
      req_new_x          <= beat.new_x;
      req_new_y          <= beat.new_y;
      req_notify         <= beat.notify;
      do @(posedge clock); while (req_stall);
      beat_count++;
      has_res = step_navigator(beat, res);
      case (check)
         CHK_PRED: if (has_res) pending_results.push_back(res);
         CHK_MOVE: begin
            res = '0;
            res.moved = 1'b1;
            res.pos_x = beat.new_x;
            res.pos_y = beat.new_y;
            pending_results.push_back(res);
         end
         default: ;
      endcase
      if (beat.req_type == REQ_TICK) begin
         pins_now = {beat.pin_b, beat.pin_a};
         sw_now   = beat.switch_pressed;
      end
      @(negedge clock);
   endtask

   // tick beat with junk in the set fields
   task automatic send_tick(input logic [1:0] ab, input logic sw);
      item_type beat;
      beat.req_type       = REQ_TICK;
      beat.pin_a          = ab[0];
      beat.pin_b          = ab[1];
      beat.switch_pressed = sw;
      beat.new_x          = 16'($urandom);
      beat.new_y          = 16'($urandom);
      beat.notify         = 1'($urandom);
      send_item(beat, CHK_PRED);
   endtask

   // hold the input quiet until every owed result is back
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (IDLE_GAP) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_Y_LOWER_LIMIT:       nav_cfg.y_lower_limit = value;
         CSR_Y_UPPER_LIMIT:       nav_cfg.y_upper_limit = value;
         CSR_ROTARY_SETTLE_TICKS: nav_cfg.rotary_settle_ticks = value;
         CSR_SWITCH_SETTLE_TICKS: nav_cfg.switch_settle_ticks = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_settings(input logic [15:0] lo, input logic [15:0] hi,
                                 input logic [15:0] rot, input logic [15:0] sw);
      wait_for_idle();
      write_reg(CSR_Y_LOWER_LIMIT, lo);
      write_reg(CSR_Y_UPPER_LIMIT, hi);
      write_reg(CSR_ROTARY_SETTLE_TICKS, rot);
      write_reg(CSR_SWITCH_SETTLE_TICKS, sw);
      csr_valid <= 1'b0;
   endtask

   // one random gesture: a clean step or press, pin noise, or a set beat
   task automatic run_gesture();
      int         pick;
      int         hold;
      int         span;
      logic [1:0] ab_next;
      logic       sw_next;
      item_type   beat;
      pick    = $urandom_range(99);
      ab_next = pins_now;
      sw_next = sw_now;
      span = (nav_cfg.rotary_settle_ticks == 16'd0) ? 1 : int'(nav_cfg.rotary_settle_ticks);
      if (int'(nav_cfg.switch_settle_ticks) > span) span = int'(nav_cfg.switch_settle_ticks);
      if (pick < 70) begin
         if (pick < 45) begin
            // mostly a gray step, sometimes both pins, sometimes with the switch
            if ($urandom_range(4) == 0) ab_next ^= 2'b11;
            else ab_next ^= $urandom_range(1) ? 2'b01 : 2'b10;
            if ($urandom_range(5) == 0) sw_next = ~sw_next;
         end else begin
            sw_next = ~sw_next;
         end
         hold = span + $urandom_range(2);
         if ($urandom_range(6) == 0) hold = $urandom_range(hold);
         send_tick(ab_next, sw_next);
         repeat (hold) send_tick(ab_next, sw_next);
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 4)) send_tick(2'($urandom), 1'($urandom));
      end else begin
         beat.req_type       = REQ_SET;
         beat.pin_a          = 1'($urandom);
         beat.pin_b          = 1'($urandom);
         beat.switch_pressed = 1'($urandom);
         beat.new_x          = 16'($urandom);
         beat.new_y          = $urandom_range(1) ? 16'($urandom)
                                                 : 16'(int'($urandom_range(20)) - 10);
         beat.notify         = 1'($urandom);
         send_item(beat, CHK_PRED);
      end
   endtask

   // receiver stall, changed on the falling edge
   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_moved !== want.moved)
               report_mismatch("moved", rsp_moved, want.moved);
            if (rsp_button_event !== want.button_event)
               report_mismatch("button_event", rsp_button_event, want.button_event);
            if (rsp_button_down !== want.button_down)
               report_mismatch("button_down", rsp_button_down, want.button_down);
            if (rsp_pos_x !== want.pos_x)
               report_mismatch("pos_x", rsp_pos_x, want.pos_x);
            if (rsp_pos_y !== want.pos_y)
               report_mismatch("pos_y", rsp_pos_y, want.pos_y);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d result beats outstanding", pending_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // stimulus
   initial begin
      int          send_idle_by_phase [3];
      int          stall_by_phase [3];
      int          start_beats;
      int          beats_sent;
      int          pick;
      dir_row_type row;
      item_type    beat;
      logic [15:0] lo;
      logic [15:0] hi;
      send_idle_by_phase = '{29, 72, 0};
      stall_by_phase     = '{72, 29, 0};
      reset_navigator();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows
      send_idle_pct = send_idle_by_phase[0];
      stall_pct     = stall_by_phase[0];
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (i == CFG_ROW) write_settings(16'hFFFF, 16'h0001, 16'd2, 16'd3);
         row = directed_rows[i];
         beat.req_type       = row.kind;
         beat.pin_a          = row.a;
         beat.pin_b          = row.b;
         beat.switch_pressed = row.sw;
         beat.new_x          = row.x;
         beat.new_y          = row.y;
         beat.notify         = row.notify;
         send_item(beat, row.check);
      end

      // random gestures under each idling mix and several settings
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_idle_by_phase[phase];
         stall_pct     = stall_by_phase[phase];
         for (int seg = 0; seg < NUM_SEGS; seg++) begin
            pick = (seg + phase) % 4;
            case (pick)
               0: begin
                  lo = 16'h8000;
                  hi = 16'h7FFF;
               end
               1: begin
                  lo = 16'(-int'($urandom_range(8)));
                  hi = 16'($urandom_range(8));
               end
               2: begin
                  // crossed limits
                  lo = 16'($urandom_range(1, 6));
                  hi = 16'(-int'($urandom_range(1, 6)));
               end
               default: begin
                  lo = 16'($urandom);
                  hi = lo;
               end
            endcase
            write_settings(lo, hi, 16'($urandom_range(5)), 16'($urandom_range(7)));
            beats_sent = 0;
            while (beats_sent < SEG_BEATS) begin
               start_beats = beat_count;
               run_gesture();
               beats_sent += beat_count - start_beats;
            end
         end
      end

      // equal settle on both groups, one combined confirmation
      write_settings(16'h8000, 16'h7FFF, 16'(LONG_SETTLE), 16'(LONG_SETTLE));
      send_tick(pins_now ^ 2'b01, ~sw_now);
      repeat (LONG_SETTLE) send_tick(pins_now, sw_now);

      wait_for_idle();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: debounced_rotary_navigator_core.f
+incdir+src
src/drn_pkg.sv
src/drn_csr.sv
src/drn_in_reg.sv
src/drn_nav.sv
src/drn_out_reg.sv
src/debounced_rotary_navigator_core.sv
src/drn_checker.sv
tb/tb_top.sv
